### hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared widths, defaults and the record types passed along the frame cells
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int LRU_MAX_FRAMES = 8;
  localparam int LRU_PAGE_BITS  = 16;

  // index and rank fields are sized for the largest supported frame count
  localparam int LRU_IDX_W   = 4;
  localparam int LRU_RANK_W  = 4;
  localparam int LRU_CNT_W   = 5;
  localparam int LRU_CFG_W   = 4;
  localparam int LRU_IN_W    = 16;
  localparam int LRU_FRAME_W = 3;
  localparam int LRU_FAULT_W = 16;

  localparam logic [LRU_CFG_W-1:0] LRU_CFG_RESET = LRU_CFG_W'(3);

  // search record, travels one cell per cycle
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [LRU_IDX_W-1:0]  hit_idx;
    logic [LRU_RANK_W-1:0] hit_rank;
    logic                  have_empty;
    logic [LRU_IDX_W-1:0]  empty_idx;
    logic                  have_vic;
    logic [LRU_IDX_W-1:0]  vic_idx;
    logic [LRU_RANK_W-1:0] worst;
  } srch_t;

  // update command, broadcast to all cells
  typedef struct packed {
    logic                  en;
    logic [LRU_IDX_W-1:0]  target;
    logic [LRU_RANK_W-1:0] limit;
    logic                  age_all;
    logic                  wr_page;
  } upd_t;

endpackage

### hdl/lru_cell.sv
// ----------------------------------------------------------------------------
// lru_cell
// one page frame: holds page, valid and recency rank, adds its own
// contribution to the passing search record and applies rank updates
// ----------------------------------------------------------------------------
module lru_cell #(
  parameter int MAX_FRAMES = lru_pkg::LRU_MAX_FRAMES,
  parameter int PAGE_BITS  = lru_pkg::LRU_PAGE_BITS,
  parameter int CELL_IDX   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  input  logic [PAGE_BITS-1:0] page_i,
  input  lru_pkg::srch_t       rec_i,
  output lru_pkg::srch_t       rec_o,
  input  lru_pkg::upd_t        upd_i
);
  import lru_pkg::*;

  localparam logic [LRU_IDX_W-1:0]  MY_IDX   = LRU_IDX_W'(CELL_IDX);
  localparam logic [LRU_RANK_W-1:0] RANK_TOP = LRU_RANK_W'(MAX_FRAMES - 1);

  logic [PAGE_BITS-1:0]  page_r;
  logic                  valid_r;
  logic [LRU_RANK_W-1:0] rank_r;
  srch_t                 rec_r;
  srch_t                 rec_nxt;

  always_comb begin
    rec_nxt = rec_i;
    if (active && valid_r) begin
      if (!rec_i.hit && (page_r == page_i)) begin
        rec_nxt.hit      = 1'b1;
        rec_nxt.hit_idx  = MY_IDX;
        rec_nxt.hit_rank = rank_r;
      end
      if (!rec_i.have_vic || (rank_r > rec_i.worst)) begin
        rec_nxt.have_vic = 1'b1;
        rec_nxt.vic_idx  = MY_IDX;
        rec_nxt.worst    = rank_r;
      end
    end else if (active && !rec_i.have_empty) begin
      rec_nxt.have_empty = 1'b1;
      rec_nxt.empty_idx  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd_i.en && active) begin
      if (upd_i.target == MY_IDX) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (upd_i.age_all || (rank_r < upd_i.limit)) &&
                   (rank_r < RANK_TOP)) begin
        rank_r <= rank_r + LRU_RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i.en && active && upd_i.wr_page && (upd_i.target == MY_IDX)) begin
      page_r <= page_i;
    end
  end

  assign rec_o = rec_r;

endmodule

### hdl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// least recently used page replacement over a small fully associative
// set of frames, built as a chain of frame cells
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one page reference per request; out_valid/
//   out_ready return hit, frame and the running fault count for it.
//   cfg_wr_en/cfg_wr_data set the number of frames in use (0 acts as 1,
//   values above MAX_FRAMES act as MAX_FRAMES); write only while idle.
//   a search record walks the cell chain one frame per cycle; the last
//   cell's record is registered as the replacement decision, which is then
//   committed to the output register. a new request is taken only once the
//   previous one has been committed to the output register.
//   a request is taken while the previous result still waits in the output
//   register; if the receiver stalls, the finished search holds until the
//   output register is free.
//   reset empties all frames, clears ranks and the fault count and sets
//   the frame count to 3; the block takes requests right after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int MAX_FRAMES = lru_pkg::LRU_MAX_FRAMES,
  parameter int PAGE_BITS  = lru_pkg::LRU_PAGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lru_pkg::LRU_CFG_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lru_pkg::LRU_IN_W-1:0]  in_page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lru_pkg::LRU_FRAME_W-1:0] out_frame,
  output logic [lru_pkg::LRU_FAULT_W-1:0] out_fault_count
);
  import lru_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [LRU_CNT_W-1:0] CNT_MAX = LRU_CNT_W'(MAX_FRAMES);

  logic [1:0]              state_r, state_nxt;
  logic [LRU_CFG_W-1:0]    cfg_frames_r;
  logic [LRU_CNT_W-1:0]    n_act;
  logic [MAX_FRAMES-1:0]   act;
  logic [PAGE_BITS-1:0]    page_r;
  logic [31:0]             page_ext;
  logic                    start_r;
  srch_t                   recs [0:MAX_FRAMES];
  srch_t                   rec_last;
  upd_t                    upd;

  logic                    dec_hit_r;
  logic [LRU_IDX_W-1:0]    dec_used_r;
  logic [LRU_RANK_W-1:0]   dec_limit_r;
  logic                    dec_age_all_r;

  logic [LRU_FAULT_W-1:0]  fault_r, fault_nxt;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [LRU_FRAME_W-1:0]  out_frame_r;
  logic [LRU_FAULT_W-1:0]  out_fault_r;

  logic accept, out_free, commit;

  // frame count clamp
  always_comb begin
    priority if (cfg_frames_r == '0) begin
      n_act = LRU_CNT_W'(1);
    end else if ({1'b0, cfg_frames_r} > CNT_MAX) begin
      n_act = CNT_MAX;
    end else begin
      n_act = {1'b0, cfg_frames_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= LRU_CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_frames_r <= cfg_wr_data;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == S_DONE) && out_free;
  assign page_ext = {{(32 - LRU_IN_W){1'b0}}, in_page};
  assign rec_last = recs[MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= page_ext[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= accept;
    end
  end

  assign recs[0] = '{vld: start_r, default: '0};

  // cell chain
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign act[i] = (LRU_CNT_W'(i) < n_act);

    lru_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .active (act[i]),
      .page_i (page_r),
      .rec_i  (recs[i]),
      .rec_o  (recs[i+1]),
      .upd_i  (upd)
    );
  end

  // replacement decision
  always_ff @(posedge clk) begin
    if (rec_last.vld) begin
      dec_hit_r     <= rec_last.hit;
      dec_age_all_r <= !rec_last.hit && rec_last.have_empty;
      if (rec_last.hit) begin
        dec_used_r  <= rec_last.hit_idx;
        dec_limit_r <= rec_last.hit_rank;
      end else if (rec_last.have_empty) begin
        dec_used_r  <= rec_last.empty_idx;
        dec_limit_r <= rec_last.worst;
      end else begin
        dec_used_r  <= rec_last.vic_idx;
        dec_limit_r <= rec_last.worst;
      end
    end
  end

  always_comb begin
    upd.en      = commit;
    upd.target  = dec_used_r;
    upd.limit   = dec_limit_r;
    upd.age_all = dec_age_all_r;
    upd.wr_page = !dec_hit_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (rec_last.vld) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // saturating fault count
  always_comb begin
    fault_nxt = fault_r;
    if (!dec_hit_r && (fault_r != '1)) begin
      fault_nxt = fault_r + LRU_FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (commit) begin
      fault_r <= fault_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= dec_hit_r;
      out_frame_r <= dec_used_r[LRU_FRAME_W-1:0];
      out_fault_r <= fault_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame       = out_frame_r;
  assign out_fault_count = out_fault_r;

endmodule
